// ===== design/mpdm_pkg.sv =====
// Shared constants, types and symbol mapping for the multi-pattern matcher.
package mpdm_pkg;

    localparam int NODES    = 1024;
    localparam int ALPHABET = 62;
    localparam int NODE_W   = $clog2(NODES);
    localparam int SYM_W    = $clog2(ALPHABET);
    localparam int EDGES    = NODES * ALPHABET;
    localparam int EDGE_W   = $clog2(EDGES);
    localparam int FREE_W   = NODE_W + 1;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_BUILD  = 2'd2,
        REQ_SCAN   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] code;
    } sym_code_t;

    function automatic sym_code_t map_symbol(input logic [7:0] b);
        sym_code_t r;
        r.valid = 1'b1;
        r.code  = '0;
        if (b >= 8'h61 && b <= 8'h7a)
            r.code = SYM_W'(b - 8'h61);
        else if (b >= 8'h41 && b <= 8'h5a)
            r.code = SYM_W'(b - 8'h41 + 8'd26);
        else if (b >= 8'h30 && b <= 8'h39)
            r.code = SYM_W'(b - 8'h30 + 8'd52);
        else
            r.valid = 1'b0;
        return r;
    endfunction

    function automatic logic [EDGE_W-1:0] edge_addr(input logic [NODE_W-1:0] n,
                                                    input logic [SYM_W-1:0] c);
        logic [EDGE_W-1:0] base;
        base = EDGE_W'(n) * EDGE_W'(ALPHABET);
        return base + EDGE_W'(c);
    endfunction

endpackage

// ===== design/multi_pattern_dfa_matcher.sv =====
// Multi-pattern matcher: trie and dense transition memories with a sequencer.
// Scan steps: edge read, end-mark read, count, result.
// Insert: edge read, node write, result; out-of-alphabet scan or discarded insert symbol: result only.
// Build: per queued node a queue read, pop, fail read, two-step pass over each symbol; clear: NODES*ALPHABET sweep.
// After reset the same clearing sweep runs before a request is taken.
// One request in flight; the next is taken once back in idle with the result register free.
module multi_pattern_dfa_matcher
    import mpdm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [7:0]  symbol,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        match,
    output logic [15:0] match_count,
    output logic [1:0]  status,
    output logic        text_done
);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_INS_RD, S_INS_WR, S_SCAN_RD, S_SCAN_EM,
        S_B_RD, S_B_POP, S_B_NODE, S_B_EDGE, S_B_EDGE2, S_RESP
    } state_t;

    // memories
    logic [NODE_W-1:0] trans_mem [EDGES];
    logic              tree_mem  [EDGES];
    logic [NODE_W-1:0] fail_mem  [NODES];
    logic              end_mem   [NODES];
    logic [NODE_W-1:0] queue_mem [NODES];

    state_t state_reg;
    logic [EDGE_W-1:0] clr_reg;
    logic [FREE_W-1:0] free_reg;
    logic [NODE_W-1:0] cur_reg, ins_reg, bcur_reg, blk_reg;
    logic              discard_reg;
    logic [15:0]       cnt_reg;
    logic [1:0]        rq_reg;
    logic              last_reg;
    sym_code_t         sc_reg;
    logic [FREE_W-1:0] head_reg, tail_reg;
    logic [SYM_W-1:0]  bi_reg;
    logic              out_valid_reg, match_reg, done_reg;
    logic [15:0]       count_out_reg;
    logic [1:0]        status_reg;

    // read ports (registered data)
    logic [EDGE_W-1:0] ta_addr, tb_addr;
    logic [NODE_W-1:0] ta_q, tb_q;
    logic              tree_q;
    logic [NODE_W-1:0] na_addr;
    logic [NODE_W-1:0] fail_q, queue_q;
    logic              end_q, end_lk_q;
    logic [NODE_W-1:0] lk_addr;

    logic              t_we, tree_we, f_we, e_we, q_we;
    logic [EDGE_W-1:0] t_wa;
    logic [NODE_W-1:0] t_wd, f_wa, f_wd, e_wa, q_wa, q_wd;
    logic              tree_wd, e_wd;

    always_ff @(posedge clk)
    begin
        ta_q     <= trans_mem[ta_addr];
        tree_q   <= tree_mem[ta_addr];
        tb_q     <= trans_mem[tb_addr];
        fail_q   <= fail_mem[na_addr];
        end_q    <= end_mem[na_addr];
        end_lk_q <= end_mem[lk_addr];
        queue_q  <= queue_mem[head_reg[NODE_W-1:0]];
        if (t_we)
            trans_mem[t_wa] <= t_wd;
        if (tree_we)
            tree_mem[t_wa] <= tree_wd;
        if (f_we)
            fail_mem[f_wa] <= f_wd;
        if (e_we)
            end_mem[e_wa] <= e_wd;
        if (q_we)
            queue_mem[q_wa] <= q_wd;
    end

    sym_code_t         sc_in;
    logic              out_free;
    logic [NODE_W-1:0] pop_node;
    assign sc_in    = map_symbol(symbol);
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    // root is the first queue entry
    assign pop_node = (head_reg == '0) ? '0 : queue_q;

    // address and write selection
    always_comb
    begin
        ta_addr = edge_addr(ins_reg, sc_reg.code);
        tb_addr = '0;
        na_addr = '0;
        lk_addr = '0;
        t_we = 1'b0; tree_we = 1'b0; f_we = 1'b0; e_we = 1'b0; q_we = 1'b0;
        t_wa = '0; t_wd = '0; tree_wd = 1'b0;
        f_wa = '0; f_wd = '0; e_wa = '0; e_wd = 1'b0; q_wa = '0; q_wd = '0;
        case (state_reg)
            S_CLR:
            begin
                t_we = 1'b1; tree_we = 1'b1; t_wa = clr_reg;
                if (clr_reg < EDGE_W'(NODES))
                begin
                    f_we = 1'b1; e_we = 1'b1;
                    f_wa = clr_reg[NODE_W-1:0]; e_wa = clr_reg[NODE_W-1:0];
                end
            end
            S_INS_RD: ta_addr = edge_addr(ins_reg, sc_reg.code);
            S_SCAN_RD: ta_addr = edge_addr(cur_reg, sc_reg.code);
            S_SCAN_EM: na_addr = ta_q;
            S_INS_WR:
            begin
                if (!tree_q && free_reg < FREE_W'(NODES))
                begin
                    t_we = 1'b1; tree_we = 1'b1; tree_wd = 1'b1;
                    t_wa = edge_addr(ins_reg, sc_reg.code);
                    t_wd = free_reg[NODE_W-1:0];
                end
                if (last_reg && (tree_q || free_reg < FREE_W'(NODES)))
                begin
                    e_we = 1'b1; e_wd = 1'b1;
                    e_wa = tree_q ? ta_q : free_reg[NODE_W-1:0];
                end
            end
            S_B_POP: na_addr = pop_node;
            S_B_NODE:
            begin
                lk_addr = fail_q;
                na_addr = bcur_reg;
            end
            S_B_EDGE:
            begin
                if (bi_reg == '0)
                begin
                    e_we = 1'b1; e_wa = bcur_reg; e_wd = end_q | end_lk_q;
                end
                ta_addr = edge_addr(bcur_reg, bi_reg);
                tb_addr = edge_addr(blk_reg, bi_reg);
            end
            S_B_EDGE2:
            begin
                ta_addr = edge_addr(bcur_reg, bi_reg);
                tb_addr = edge_addr(blk_reg, bi_reg);
                if (tree_q)
                begin
                    f_we = 1'b1; f_wa = ta_q;
                    f_wd = (bcur_reg != '0) ? tb_q : '0;
                    if (tail_reg < FREE_W'(NODES))
                    begin
                        q_we = 1'b1; q_wa = tail_reg[NODE_W-1:0]; q_wd = ta_q;
                    end
                end
                else
                begin
                    t_we = 1'b1; t_wa = edge_addr(bcur_reg, bi_reg); t_wd = tb_q;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            free_reg      <= FREE_W'(1);
            cur_reg       <= '0;
            ins_reg       <= '0;
            discard_reg   <= 1'b0;
            cnt_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            bi_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + EDGE_W'(1);
                    if (clr_reg == EDGE_W'(EDGES - 1))
                    begin
                        clr_reg <= '0;
                        state_reg <= (free_reg == '0) ? S_RESP : S_IDLE;
                        free_reg <= FREE_W'(1);
                        cur_reg <= '0; ins_reg <= '0; discard_reg <= 1'b0; cnt_reg <= '0;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid && out_free)
                    begin
                        rq_reg <= req_type; last_reg <= last; sc_reg <= sc_in;
                        match_reg <= 1'b0; count_out_reg <= '0; done_reg <= 1'b0;
                        status_reg <= ST_OK;
                        case (req_t'(req_type))
                            REQ_CLEAR:
                            begin
                                free_reg  <= '0;
                                state_reg <= S_CLR;
                            end
                            REQ_INSERT:
                            begin
                                if (!sc_in.valid)
                                    status_reg <= ST_RANGE;
                                if (discard_reg || !sc_in.valid)
                                begin
                                    if (last)
                                    begin
                                        ins_reg <= '0; discard_reg <= 1'b0;
                                    end
                                    else
                                        discard_reg <= 1'b1;
                                    state_reg <= S_RESP;
                                end
                                else
                                    state_reg <= S_INS_RD;
                            end
                            REQ_BUILD:
                            begin
                                head_reg <= '0; tail_reg <= FREE_W'(1);
                                state_reg <= S_B_RD;
                            end
                            default:
                            begin
                                if (!sc_in.valid)
                                begin
                                    status_reg <= ST_RANGE;
                                    cur_reg <= '0;
                                    count_out_reg <= cnt_reg;
                                    done_reg <= last;
                                    if (last)
                                    begin
                                        cnt_reg <= '0;
                                    end
                                    state_reg <= S_RESP;
                                end
                                else
                                    state_reg <= S_SCAN_RD;
                            end
                        endcase
                    end
                end
                S_INS_RD: state_reg <= S_INS_WR;
                S_INS_WR:
                begin
                    if (tree_q)
                        ins_reg <= ta_q;
                    else if (free_reg < FREE_W'(NODES))
                    begin
                        ins_reg <= free_reg[NODE_W-1:0];
                        free_reg <= free_reg + FREE_W'(1);
                    end
                    else
                    begin
                        status_reg <= ST_FULL;
                        discard_reg <= 1'b1;
                    end
                    if (last_reg)
                    begin
                        ins_reg <= '0; discard_reg <= 1'b0;
                    end
                    state_reg <= S_RESP;
                end
                S_SCAN_RD: state_reg <= S_SCAN_EM;
                S_SCAN_EM:
                begin
                    cur_reg <= ta_q;
                    state_reg <= S_RESP;
                end
                S_B_RD: state_reg <= S_B_POP;
                S_B_POP:
                begin
                    bcur_reg <= pop_node;
                    head_reg <= head_reg + FREE_W'(1);
                    state_reg <= S_B_NODE;
                end
                S_B_NODE:
                begin
                    blk_reg <= fail_q;
                    bi_reg <= '0;
                    state_reg <= S_B_EDGE;
                end
                S_B_EDGE: state_reg <= S_B_EDGE2;
                S_B_EDGE2:
                begin
                    if (tree_q && tail_reg < FREE_W'(NODES))
                        tail_reg <= tail_reg + FREE_W'(1);
                    if (bi_reg == SYM_W'(ALPHABET - 1))
                    begin
                        if (head_reg < tail_reg
                            || (tree_q && tail_reg < FREE_W'(NODES)))
                            state_reg <= S_B_RD;
                        else
                            state_reg <= S_RESP;
                    end
                    else
                    begin
                        bi_reg <= bi_reg + SYM_W'(1);
                        state_reg <= S_B_EDGE;
                    end
                end
                S_RESP:
                begin
                    if (rq_reg == REQ_SCAN && sc_reg.valid)
                    begin
                        done_reg <= last_reg;
                        if (end_q)
                        begin
                            match_reg <= 1'b1;
                            cur_reg <= '0;
                            count_out_reg <= (cnt_reg != 16'hFFFF) ? cnt_reg + 16'd1 : cnt_reg;
                            cnt_reg <= (cnt_reg != 16'hFFFF) ? cnt_reg + 16'd1 : cnt_reg;
                        end
                        else
                            count_out_reg <= cnt_reg;
                        if (last_reg)
                        begin
                            cnt_reg <= '0; cur_reg <= '0;
                        end
                        sc_reg.valid <= 1'b0;
                    end
                    else if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign match       = match_reg;
    assign match_count = count_out_reg;
    assign status      = status_reg;
    assign text_done   = done_reg;

    a_one_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while busy");
    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(match_count))
        else $error("result dropped");
    a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (free_reg != '0 && free_reg <= FREE_W'(NODES)))
        else $error("node counter out of range");
endmodule

// ===== bench/multi_pattern_dfa_matcher_chk.sv =====
// Checker for the multi-pattern matcher: automaton predictor and result scoreboard.
module multi_pattern_dfa_matcher_chk
    import mpdm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [7:0]  symbol,
    input  logic        last,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        match,
    input  logic [15:0] match_count,
    input  logic [1:0]  status,
    input  logic        text_done,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        match;
        logic [15:0] count;
        status_t     status;
        logic        done;
    } result_t;

    logic [NODE_W-1:0] goto_tbl [EDGES];
    bit                tree_bit [EDGES];
    logic [NODE_W-1:0] fail_tbl [NODES];
    bit                accept   [NODES];
    int unsigned       free_node;
    int unsigned       scan_node;
    int unsigned       hits;
    int unsigned       grow_node;
    bit                grow_drop;
    result_t           awaited [$];

    function automatic int dense_code(input logic [7:0] b);
        if (b >= "a" && b <= "z") return int'(b) - "a";
        if (b >= "A" && b <= "Z") return int'(b) - "A" + 26;
        if (b >= "0" && b <= "9") return int'(b) - "0" + 52;
        return -1;
    endfunction

    function automatic void wipe_trie();
        for (int i = 0; i < EDGES; i++)
        begin
            goto_tbl[i] = '0;
            tree_bit[i] = 0;
        end
        for (int i = 0; i < NODES; i++)
        begin
            fail_tbl[i] = '0;
            accept[i]   = 0;
        end
        free_node = 1;
        scan_node = 0;
        hits      = 0;
        grow_node = 0;
        grow_drop = 0;
    endfunction

    function automatic status_t grow_trie(input logic [7:0] b, input bit fin);
        status_t st;
        int      c;
        int      e;
        st = ST_OK;
        c  = dense_code(b);
        if (c < 0) st = ST_RANGE;
        if (!grow_drop)
        begin
            if (c < 0)
                grow_drop = 1;
            else
            begin
                e = grow_node * ALPHABET + c;
                if (tree_bit[e])
                    grow_node = goto_tbl[e];
                else if (free_node < NODES)
                begin
                    goto_tbl[e] = NODE_W'(free_node);
                    tree_bit[e] = 1;
                    grow_node   = free_node;
                    free_node++;
                end
                else
                begin
                    st        = ST_FULL;
                    grow_drop = 1;
                end
                if (fin && !grow_drop) accept[grow_node] = 1;
            end
        end
        if (fin)
        begin
            grow_node = 0;
            grow_drop = 0;
        end
        return st;
    endfunction

    function automatic void link_trie();
        int unsigned order [NODES];
        int unsigned head;
        int unsigned tail;
        int unsigned cur;
        int unsigned lk;
        int unsigned w;
        head = 0;
        tail = 1;
        order[0] = 0;
        while (head < tail)
        begin
            cur = order[head];
            head++;
            lk = fail_tbl[cur];
            accept[cur] = accept[cur] | accept[lk];
            for (int i = 0; i < ALPHABET; i++)
            begin
                if (tree_bit[cur*ALPHABET+i])
                begin
                    w = goto_tbl[cur*ALPHABET+i];
                    fail_tbl[w] = (cur != 0) ? goto_tbl[lk*ALPHABET+i] : '0;
                    if (tail < NODES)
                    begin
                        order[tail] = w;
                        tail++;
                    end
                end
                else
                    goto_tbl[cur*ALPHABET+i] = goto_tbl[lk*ALPHABET+i];
            end
        end
    endfunction

    function automatic result_t predict(input req_t rq, input logic [7:0] b, input bit fin);
        result_t r;
        int      c;
        int unsigned v;
        r = '0;
        case (rq)
            REQ_CLEAR:  wipe_trie();
            REQ_INSERT: r.status = grow_trie(b, fin);
            REQ_BUILD:  link_trie();
            default:
            begin
                c = dense_code(b);
                if (c < 0)
                begin
                    r.status  = ST_RANGE;
                    scan_node = 0;
                end
                else
                begin
                    v = goto_tbl[scan_node*ALPHABET+c];
                    if (accept[v])
                    begin
                        r.match = 1;
                        if (hits < 16'hFFFF) hits++;
                        v = 0;
                    end
                    scan_node = v;
                end
                r.count = 16'(hits);
                r.done  = fin;
                if (fin)
                begin
                    hits      = 0;
                    scan_node = 0;
                end
            end
        endcase
        return r;
    endfunction

    initial
    begin
        errors  = 0;
        pending = 0;
        wipe_trie();
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && in_valid && in_ready)
            awaited.push_back(predict(req_t'(req_type), symbol, last));
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result match=%0b count=%0d status=%0d done=%0b",
                         $time, match, match_count, status, text_done);
            end
            else
            begin
                want = awaited.pop_front();
                if (match !== want.match)
                begin
                    errors++;
                    $display("%0t: match exp %0b got %0b", $time, want.match, match);
                end
                if (match_count !== want.count)
                begin
                    errors++;
                    $display("%0t: match_count exp %0d got %0d", $time, want.count,
                             match_count);
                end
                if (status !== want.status)
                begin
                    errors++;
                    $display("%0t: status exp %0d got %0d", $time, want.status, status);
                end
                if (text_done !== want.done)
                begin
                    errors++;
                    $display("%0t: text_done exp %0b got %0b", $time, want.done, text_done);
                end
            end
        end
        pending = awaited.size();
    end

endmodule

// ===== bench/multi_pattern_dfa_matcher_tb.sv =====
// Testbench top for the multi-pattern matcher: stimulus, back-pressure and verdict.
module multi_pattern_dfa_matcher_tb;
    import mpdm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_type;
    logic [7:0]  symbol;
    logic        last;
    logic        out_valid;
    logic        out_ready;
    logic        match;
    logic [15:0] match_count;
    logic [1:0]  status;
    logic        text_done;
    int          errors;
    int          pending;
    logic        hold_req;
    int          idle_cycles;

    multi_pattern_dfa_matcher i_dut (.*);

    multi_pattern_dfa_matcher_chk i_chk (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] alpha_char(input int k);
        if (k < 26) return 8'("a" + k);
        if (k < 52) return 8'("A" + k - 26);
        return 8'("0" + k - 52);
    endfunction

    // small letter set so that texts hit patterns often
    function automatic logic [7:0] narrow_char();
        int pick [7] = '{0, 1, 2, 26, 27, 52, 53};
        return alpha_char(pick[$urandom_range(0, 6)]);
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send(input req_t rq, input logic [7:0] b, input bit fin);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rq;
        symbol   <= b;
        last     <= fin;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
    endtask

    task automatic send_word(input req_t rq, input string s);
        for (int i = 0; i < s.len(); i++)
            send(rq, s[i], i == s.len() - 1);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic random_text(input int len, input bit noisy);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            b = (noisy && $urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                                     : narrow_char();
            send(REQ_SCAN, b, i == len - 1);
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_CLEAR;
        symbol   = '0;
        last     = 1'b0;
        hold_req = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        send_word(REQ_INSERT, "he");
        send_word(REQ_INSERT, "she");
        send_word(REQ_INSERT, "hers");
        send(REQ_INSERT, "x", 0);
        send(REQ_INSERT, "!", 1);
        send_word(REQ_INSERT, "aZ");
        send_word(REQ_INSERT, "A09z");
        send_word(REQ_SCAN, "she");
        send(REQ_BUILD, 8'hFF, 1);
        send(REQ_SCAN, "s", 0);
        send(REQ_SCAN, 8'h00, 0);
        send(REQ_SCAN, "h", 0);
        send(REQ_SCAN, 8'hFF, 0);
        send_word(REQ_SCAN, "shers");
        send(REQ_CLEAR, 8'hA5, 1);
        send(REQ_SCAN, "h", 1);

        // random rounds of inserts, build and scans
        for (int r = 0; r < 12; r++)
        begin
            if (r % 4 == 3) send(REQ_CLEAR, 8'($urandom_range(0, 255)), $urandom_range(0, 1));
            for (int p = $urandom_range(2, 6); p > 0; p--)
            begin
                int len;
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++)
                    send(REQ_INSERT,
                         ($urandom_range(0, 14) == 0) ? 8'($urandom_range(0, 255))
                                                      : narrow_char(),
                         i == len - 1);
            end
            send(REQ_BUILD, 8'($urandom_range(0, 255)), $urandom_range(0, 1));
            if (r == 5)
            begin
                drain();
                hold_req = 1'b1;
            end
            if (r % 3 == 1)
            begin
                send(REQ_INSERT, narrow_char(), 1);
                send(REQ_BUILD, 8'h00, 0);
            end
            for (int t = $urandom_range(3, 6); t > 0; t--)
                random_text($urandom_range(1, 20), 1);
            for (int n = $urandom_range(0, 3); n > 0; n--)
            begin
                logic [1:0] q;
                q = 2'($urandom_range(0, 3));
                if (q == REQ_CLEAR) q = REQ_SCAN;
                send(req_t'(q), 8'($urandom_range(0, 255)), $urandom_range(0, 1));
            end
            if (r == 9) drain();
        end

        // fill the node table to its limit
        send(REQ_CLEAR, 8'h00, 0);
        for (int i = 0; i < 1100; i++)
            send(REQ_INSERT, alpha_char($urandom_range(0, 61)), (i % 8) == 7);
        send(REQ_BUILD, 8'h00, 1);
        for (int t = 0; t < 6; t++)
            for (int i = 0; i < 15; i++)
                send(REQ_SCAN, alpha_char($urandom_range(0, 61)), i == 14);

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        int len;
        out_ready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                len = gap_len();
                if (len > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (len) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
            repeat (len) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial idle_cycles = 0;

endmodule

// ===== filelist.f =====
design/mpdm_pkg.sv
design/multi_pattern_dfa_matcher.sv
bench/multi_pattern_dfa_matcher_chk.sv
bench/multi_pattern_dfa_matcher_tb.sv
